>>> rtl/cron_line_time_matcher_defines.svh
// assertion macros for the schedule line matcher
`ifndef CRON_LINE_TIME_MATCHER_DEFINES_SVH
`define CRON_LINE_TIME_MATCHER_DEFINES_SVH

// property checked at every clock edge outside reset
`define CLT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every clock edge, reset included
`define CLT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/clt_pkg.sv
`default_nettype none

package clt_pkg;

  // field parser phases
  localparam logic [2:0] PH_EMPTY   = 3'd0;
  localparam logic [2:0] PH_DIGITS  = 3'd1;
  localparam logic [2:0] PH_STAR    = 3'd2;
  localparam logic [2:0] PH_LIST    = 3'd3;
  localparam logic [2:0] PH_RANGE   = 3'd4;
  localparam logic [2:0] PH_SETTLED = 3'd5;
  localparam logic [2:0] PH_DEAD    = 3'd6;

  // number of time fields and number saturation
  localparam logic [2:0] FIELD_COUNT = 3'd5;
  localparam logic [7:0] NUM_MAX     = 8'd255;

  // characters
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // configuration register indexes
  localparam logic [2:0] REG_MINUTE  = 3'd0;
  localparam logic [2:0] REG_HOUR    = 3'd1;
  localparam logic [2:0] REG_DAY     = 3'd2;
  localparam logic [2:0] REG_MONTH   = 3'd3;
  localparam logic [2:0] REG_WEEKDAY = 3'd4;

  // field positions
  localparam logic [2:0] FLD_MINUTE = 3'd0;
  localparam logic [2:0] FLD_HOUR   = 3'd1;
  localparam logic [2:0] FLD_DAY    = 3'd2;
  localparam logic [2:0] FLD_MONTH  = 3'd3;

endpackage

`default_nettype wire

>>> rtl/cron_line_time_matcher.sv
// schedule line matcher: one byte per transaction, one accepted every cycle unless in_stall
// a line-end byte passes the input register, then the parser update, into the result register
// throughput: 1 byte per cycle unless in_stall; single parser update between two registers
// in_stall rises only while a line-end byte waits for a stalled result register
// reset (rst, synchronous): parser at start of line, time registers at 0/0/1/1/0
`default_nettype none
`include "cron_line_time_matcher_defines.svh"

module cron_line_time_matcher
  import clt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [5:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] line_byte,
  input  wire logic       line_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            well_formed,
  output logic            due_now
);

  // time registers
  logic [5:0] minute_now;
  logic [4:0] hour_now;
  logic [4:0] day_now;
  logic [3:0] month_now;
  logic [2:0] weekday_now;

  // input register
  logic       q_valid;
  logic [7:0] q_byte;
  logic       q_end;

  // parser state
  logic [2:0] field_number, field_number_next;
  logic [2:0] field_phase, field_phase_next;
  logic       skipping_blanks, skipping_blanks_next;
  logic [7:0] number_value, number_value_next;
  logic       list_hit, list_hit_next;
  logic       range_low_ok, range_low_ok_next;
  logic       all_fields_match, all_fields_match_next;

  // datapath helpers
  logic [7:0]  now;
  logic        is_digit, is_blank;
  logic [3:0]  digit_val;
  logic [11:0] acc_sum;
  logic [7:0]  acc_val;
  logic        eq_now, ge_now, le_now;
  logic        field_hit;
  logic        out_free, proc, take;
  logic        res_wf, res_due;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      minute_now  <= 6'd0;
      hour_now    <= 5'd0;
      day_now     <= 5'd1;
      month_now   <= 4'd1;
      weekday_now <= 3'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MINUTE:  minute_now  <= cfg_data;
        REG_HOUR:    hour_now    <= cfg_data[4:0];
        REG_DAY:     day_now     <= cfg_data[4:0];
        REG_MONTH:   month_now   <= cfg_data[3:0];
        REG_WEEKDAY: weekday_now <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // handshake control
  assign out_free = !out_valid || !out_stall;
  assign proc     = q_valid && (!q_end || out_free);
  assign in_stall = q_valid && !proc;
  assign take     = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (take) begin
      q_valid <= 1'b1;
    end else if (proc) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      q_byte <= line_byte;
      q_end  <= line_end;
    end
  end

  // time part of the current field
  always_comb begin
    case (field_number)
      FLD_MINUTE: now = {2'b00, minute_now};
      FLD_HOUR:   now = {3'b000, hour_now};
      FLD_DAY:    now = {3'b000, day_now};
      FLD_MONTH:  now = {4'b0000, month_now};
      default:    now = {5'b00000, weekday_now};
    endcase
  end

  // character classes and saturating decimal accumulate
  assign is_digit  = q_byte inside {[CH_0:CH_9]};
  assign is_blank  = (q_byte == CH_SPACE) || (q_byte == CH_TAB);
  // low nibble of an ascii digit is its value
  assign digit_val = q_byte[3:0];
  assign acc_sum   = ({4'b0000, number_value} << 3) + ({4'b0000, number_value} << 1)
                   + {8'h00, digit_val};
  assign acc_val   = (acc_sum > {4'b0000, NUM_MAX}) ? NUM_MAX : acc_sum[7:0];

  assign eq_now = (number_value == now);
  assign ge_now = (now >= number_value);
  assign le_now = (now <= number_value);

  // match of the field being closed
  always_comb begin
    case (field_phase)
      PH_EMPTY, PH_DIGITS: field_hit = eq_now;
      PH_STAR:             field_hit = 1'b1;
      PH_LIST:             field_hit = list_hit || eq_now;
      PH_RANGE:            field_hit = range_low_ok && le_now;
      default:             field_hit = list_hit;
    endcase
  end

  // parser next state for the byte in the input register
  always_comb begin
    field_number_next     = field_number;
    field_phase_next      = field_phase;
    skipping_blanks_next  = skipping_blanks;
    number_value_next     = number_value;
    list_hit_next         = list_hit;
    range_low_ok_next     = range_low_ok;
    all_fields_match_next = all_fields_match;

    if (field_number < FIELD_COUNT && field_phase != PH_DEAD) begin
      if (is_blank) begin
        // blank closes the field unless already skipping
        if (!skipping_blanks) begin
          all_fields_match_next = all_fields_match && field_hit;
          field_number_next     = field_number + 3'd1;
          field_phase_next      = PH_EMPTY;
          number_value_next     = 8'd0;
          list_hit_next         = 1'b0;
          range_low_ok_next     = 1'b0;
          skipping_blanks_next  = 1'b1;
        end
      end else begin
        skipping_blanks_next = 1'b0;
        if (q_byte == CH_NUL) begin
          field_phase_next = PH_DEAD;
        end else begin
          case (field_phase)
            PH_EMPTY, PH_DIGITS: begin
              if (is_digit) begin
                number_value_next = acc_val;
                field_phase_next  = PH_DIGITS;
              end else if (q_byte == CH_STAR && field_phase == PH_EMPTY) begin
                field_phase_next = PH_STAR;
              end else if (q_byte == CH_COMMA) begin
                list_hit_next     = eq_now;
                number_value_next = 8'd0;
                field_phase_next  = PH_LIST;
              end else if (q_byte == CH_DASH) begin
                range_low_ok_next = ge_now;
                number_value_next = 8'd0;
                field_phase_next  = PH_RANGE;
              end else begin
                list_hit_next    = 1'b0;
                field_phase_next = PH_SETTLED;
              end
            end
            PH_STAR: begin
              list_hit_next    = 1'b0;
              field_phase_next = PH_SETTLED;
            end
            PH_LIST: begin
              if (is_digit) begin
                number_value_next = acc_val;
              end else begin
                list_hit_next     = list_hit || eq_now;
                number_value_next = 8'd0;
                if (q_byte != CH_COMMA) begin
                  field_phase_next = PH_SETTLED;
                end
              end
            end
            PH_RANGE: begin
              if (is_digit) begin
                number_value_next = acc_val;
              end else begin
                list_hit_next    = range_low_ok && le_now;
                field_phase_next = PH_SETTLED;
              end
            end
            default: ;
          endcase
        end
      end
    end
  end

  // line result from the updated state
  assign res_wf  = (field_number_next >= FIELD_COUNT);
  assign res_due = res_wf && all_fields_match_next;

  // parser state registers, restart after a line end
  always_ff @(posedge clk) begin
    if (rst || (proc && q_end)) begin
      field_number     <= 3'd0;
      field_phase      <= PH_EMPTY;
      skipping_blanks  <= 1'b0;
      number_value     <= 8'd0;
      list_hit         <= 1'b0;
      range_low_ok     <= 1'b0;
      all_fields_match <= 1'b1;
    end else if (proc) begin
      field_number     <= field_number_next;
      field_phase      <= field_phase_next;
      skipping_blanks  <= skipping_blanks_next;
      number_value     <= number_value_next;
      list_hit         <= list_hit_next;
      range_low_ok     <= range_low_ok_next;
      all_fields_match <= all_fields_match_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc && q_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && q_end) begin
      well_formed <= res_wf;
      due_now     <= res_due;
    end
  end

  // checks
  `CLT_ASSERT(a_field_bound, field_number <= FIELD_COUNT, "field count past five")
  `CLT_ASSERT_ALWAYS(a_reset_clears, rst |=> !out_valid && !q_valid, "reset left data valid")
  `CLT_ASSERT(a_due_needs_wf, out_valid |-> (!due_now || well_formed), "due without well formed")
  `CLT_ASSERT(a_line_result, proc && q_end |=> out_valid, "line end gave no result")
  `CLT_ASSERT(a_line_restart, proc && q_end |=> field_number == 3'd0 && all_fields_match,
              "parser not restarted after line end")
  `CLT_ASSERT(a_stall_only_pending, in_stall |-> q_valid && q_end && out_valid,
              "input stalled with no pending line end")

endmodule

`default_nettype wire

>>> dv/cron_line_checker.sv
`timescale 1ns / 100ps

module cron_line_checker
  import clt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic [2:0] cfg_index,
  input  wire logic [5:0] cfg_data,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [7:0] line_byte,
  input  wire logic       line_end,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic       well_formed,
  input  wire logic       due_now,
  output int              fail_count,
  output int              pending
);

  typedef struct packed {
    logic well_formed;
    logic due_now;
  } verdict_t;

  // verdicts of finished lines, oldest first
  verdict_t verdict_q[$];

  // current time as the block should hold it
  logic [5:0] minute_reg;
  logic [4:0] hour_reg;
  logic [4:0] day_reg;
  logic [3:0] month_reg;
  logic [2:0] weekday_reg;

  // line parser state
  logic [2:0] field_idx;
  logic [2:0] phase;
  logic       skip_blank;
  logic [7:0] number;
  logic       hit_so_far;
  logic       low_ok;
  logic       line_match;

  int mismatches = 0;
  int lines_seen = 0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // time part that the current field is compared against
  function automatic logic [7:0] field_time();
    case (field_idx)
      FLD_MINUTE: return {2'b00, minute_reg};
      FLD_HOUR:   return {3'b000, hour_reg};
      FLD_DAY:    return {3'b000, day_reg};
      FLD_MONTH:  return {4'b0000, month_reg};
      default:    return {5'b00000, weekday_reg};
    endcase
  endfunction

  function automatic void restart_line();
    field_idx  = '0;
    phase      = PH_EMPTY;
    skip_blank = 1'b0;
    number     = '0;
    hit_so_far = 1'b0;
    low_ok     = 1'b0;
    line_match = 1'b1;
  endfunction

  // decimal accumulate, saturating
  function automatic void push_digit(input logic [7:0] c);
    int v;
    v = int'(number) * 10 + int'(c - CH_0);
    number = (v > int'(NUM_MAX)) ? NUM_MAX : v[7:0];
  endfunction

  // blank after a field: fold its outcome into the line
  function automatic void close_field();
    logic [7:0] now;
    logic       hit;
    now = field_time();
    case (phase)
      PH_EMPTY, PH_DIGITS: hit = (number == now);
      PH_STAR:             hit = 1'b1;
      PH_LIST:             hit = hit_so_far || (number == now);
      PH_RANGE:            hit = low_ok && (now <= number);
      default:             hit = hit_so_far;
    endcase
    line_match = line_match && hit;
    field_idx++;
    phase      = PH_EMPTY;
    number     = '0;
    hit_so_far = 1'b0;
    low_ok     = 1'b0;
    skip_blank = 1'b1;
  endfunction

  // non-blank character inside a time field
  function automatic void field_char(input logic [7:0] c);
    logic [7:0] now;
    logic       digit;
    now   = field_time();
    digit = (c >= CH_0) && (c <= CH_9);
    if (c == CH_NUL) begin
      phase = PH_DEAD;
    end else begin
      case (phase)
        PH_EMPTY, PH_DIGITS: begin
          if (digit) begin
            push_digit(c);
            phase = PH_DIGITS;
          end else if (c == CH_STAR && phase == PH_EMPTY) begin
            phase = PH_STAR;
          end else if (c == CH_COMMA) begin
            hit_so_far = (number == now);
            number     = '0;
            phase      = PH_LIST;
          end else if (c == CH_DASH) begin
            low_ok = (now >= number);
            number = '0;
            phase  = PH_RANGE;
          end else begin
            hit_so_far = 1'b0;
            phase      = PH_SETTLED;
          end
        end
        PH_STAR: begin
          hit_so_far = 1'b0;
          phase      = PH_SETTLED;
        end
        PH_LIST: begin
          if (digit) begin
            push_digit(c);
          end else begin
            hit_so_far = hit_so_far || (number == now);
            number     = '0;
            if (c != CH_COMMA) phase = PH_SETTLED;
          end
        end
        PH_RANGE: begin
          if (digit) begin
            push_digit(c);
          end else begin
            hit_so_far = low_ok && (now <= number);
            phase      = PH_SETTLED;
          end
        end
        default: begin
        end
      endcase
    end
  endfunction

  // one byte of the line; returns 1 with the verdict on the last byte
  function automatic logic scan_byte(input logic [7:0] c, input logic last,
                                     output verdict_t v);
    logic blank;
    blank = (c == CH_SPACE) || (c == CH_TAB);
    v = '0;
    if (field_idx < FIELD_COUNT && phase != PH_DEAD) begin
      if (blank) begin
        if (!skip_blank) close_field();
      end else begin
        skip_blank = 1'b0;
        field_char(c);
      end
    end
    if (last) begin
      v.well_formed = (field_idx >= FIELD_COUNT);
      v.due_now     = v.well_formed && line_match;
      restart_line();
    end
    return last;
  endfunction

  // watch both channels and the register port
  always @(posedge clk) begin
    verdict_t fresh;
    verdict_t want;
    if (rst) begin
      minute_reg  = '0;
      hour_reg    = '0;
      day_reg     = 5'd1;
      month_reg   = 4'd1;
      weekday_reg = '0;
      restart_line();
      verdict_q.delete();
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          REG_MINUTE:  minute_reg  = cfg_data;
          REG_HOUR:    hour_reg    = cfg_data[4:0];
          REG_DAY:     day_reg     = cfg_data[4:0];
          REG_MONTH:   month_reg   = cfg_data[3:0];
          REG_WEEKDAY: weekday_reg = cfg_data[2:0];
          default: begin
          end
        endcase
      end

      // accepted byte transaction
      if (in_valid && !in_stall) begin
        if (scan_byte(line_byte, line_end, fresh)) verdict_q.push_back(fresh);
      end

      // accepted result transaction
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          report_mismatch("result with no finished line waiting");
        end else begin
          want = verdict_q.pop_front();
          if (well_formed !== want.well_formed)
            report_mismatch($sformatf("line %0d well_formed %b, expected %b",
                                      lines_seen, well_formed, want.well_formed));
          if (due_now !== want.due_now)
            report_mismatch($sformatf("line %0d due_now %b, expected %b",
                                      lines_seen, due_now, want.due_now));
          lines_seen++;
        end
      end
    end
    fail_count <= mismatches;
    pending    <= verdict_q.size();
  end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps

module tb;
  import clt_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_BYTES  = 170;
  localparam int PHASE_LINES  = 6;
  localparam int DRAIN_CYCLES = 4;

  // idling modes
  localparam int IDLE_NONE     = 0;
  localparam int IDLE_SENDER   = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH     = 3;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [2:0] cfg_index;
  logic [5:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] line_byte;
  logic       line_end;
  logic       out_valid;
  logic       out_stall;
  logic       well_formed;
  logic       due_now;
  int         fail_count;
  int         pending;

  int         idle_pct;
  int         stall_pct;
  int         hold_requests;
  int         holds_served;
  int         hold_left;
  int         cycle_count = 0;
  int         now_val [5];
  logic [7:0] line_buf [$];

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  cron_line_time_matcher i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .line_byte   (line_byte),
    .line_end    (line_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .well_formed (well_formed),
    .due_now     (due_now)
  );

  cron_line_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .line_byte   (line_byte),
    .line_end    (line_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .well_formed (well_formed),
    .due_now     (due_now),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall    <= 1'b0;
      holds_served <= 0;
      hold_left    <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      out_stall    <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic put_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  task automatic put_number(input int n);
    put_text($sformatf("%0d", n));
  endtask

  task automatic put_blanks();
    int n;
    n = $urandom_range(3, 1);
    repeat (n) line_buf.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
  endtask

  // numbers lean toward the time part so that fields often match
  function automatic int pick_value(input int t);
    int r;
    r = $urandom_range(99);
    if (r < 45) return t;
    else if (r < 60) return t + 1;
    else if (r < 70) return (t > 0) ? t - 1 : 0;
    else if (r < 95) return $urandom_range(63);
    else return $urandom_range(999);
  endfunction

  // one time field: star, number, list, range or an odd form
  task automatic put_field(input int f);
    int t, k, n, i;
    t = now_val[f];
    k = $urandom_range(99);
    if (k < 20) begin
      line_buf.push_back(CH_STAR);
    end else if (k < 45) begin
      put_number(pick_value(t));
    end else if (k < 65) begin
      n = $urandom_range(4, 2);
      for (i = 0; i < n; i++) begin
        if (i != 0) line_buf.push_back(CH_COMMA);
        put_number(pick_value(t));
      end
    end else if (k < 85) begin
      if ($urandom_range(1)) begin
        n = t - int'($urandom_range(3));
        put_number((n < 0) ? 0 : n);
        line_buf.push_back(CH_DASH);
        put_number(t + int'($urandom_range(3)));
      end else begin
        put_number(pick_value(t));
        line_buf.push_back(CH_DASH);
        put_number(pick_value(t));
      end
    end else begin
      // leading separator, star with trailer, tail after list or range, lone byte
      case ($urandom_range(3))
        0: begin
          line_buf.push_back($urandom_range(1) ? CH_COMMA : CH_DASH);
          put_number(pick_value(t));
        end
        1: begin
          line_buf.push_back(CH_STAR);
          line_buf.push_back(8'($urandom_range(255)));
        end
        2: begin
          put_number(pick_value(t));
          line_buf.push_back($urandom_range(1) ? CH_COMMA : CH_DASH);
          put_number(pick_value(t));
          line_buf.push_back(8'($urandom_range(126, 33)));
          put_number(pick_value(t));
        end
        default: begin
          line_buf.push_back(8'($urandom_range(255)));
        end
      endcase
    end
  endtask

  // mostly clean lines, some noise, truncated or corrupted lines
  task automatic build_line();
    int f, n, cut, kind;
    line_buf.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      n = $urandom_range(12, 1);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      if ($urandom_range(19) == 0) put_blanks();
      for (f = 0; f < FIELD_COUNT; f++) begin
        put_field(f);
        put_blanks();
      end
      n = $urandom_range(8);
      repeat (n) line_buf.push_back(8'($urandom_range(255)));
      if (kind < 25) begin
        cut = $urandom_range(line_buf.size(), 1);
        while (line_buf.size() > cut) void'(line_buf.pop_back());
      end else if (kind < 33) begin
        line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
      end
    end
  endtask

  // one byte transaction per character, line_end on the last
  task automatic send_line();
    int i;
    for (i = 0; i < line_buf.size(); i++) begin
      while ($urandom_range(99) < idle_pct) begin
        in_valid  <= 1'b0;
        line_byte <= 8'($urandom_range(255));
        @(posedge clk);
      end
      in_valid  <= 1'b1;
      line_byte <= line_buf[i];
      line_end  <= (i == line_buf.size() - 1);
      @(posedge clk);
      while (in_stall) @(posedge clk);
    end
  endtask

  task automatic send_text(input string s);
    line_buf.delete();
    put_text(s);
    send_line();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[5:0];
    @(posedge clk);
  endtask

  // all five time registers, then a write to an unused index
  task automatic load_time(input int m, input int h, input int d, input int mo,
                           input int w);
    write_reg(REG_MINUTE, m);
    write_reg(REG_HOUR, h);
    write_reg(REG_DAY, d);
    write_reg(REG_MONTH, mo);
    write_reg(REG_WEEKDAY, w);
    write_reg(3'($urandom_range(7, int'(REG_WEEKDAY) + 1)), $urandom_range(63));
    cfg_write <= 1'b0;
    now_val = '{m & 'h3f, h & 'h1f, d & 'h1f, mo & 'h0f, w & 'h07};
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      IDLE_NONE: begin
        idle_pct = 0;
        stall_pct <= 0;
      end
      IDLE_SENDER: begin
        idle_pct = 65;
        stall_pct <= 0;
      end
      IDLE_RECEIVER: begin
        idle_pct = 0;
        stall_pct <= 65;
      end
      default: begin
        idle_pct = 37;
        stall_pct <= 37;
      end
    endcase
  endtask

  // stimulus and verdict
  initial begin
    int p, phase_bytes, phase_lines;
    rst           <= 1'b1;
    cfg_write     <= 1'b0;
    cfg_index     <= REG_MINUTE;
    cfg_data      <= '0;
    in_valid      <= 1'b0;
    line_byte     <= '0;
    line_end      <= 1'b0;
    stall_pct     <= 0;
    hold_requests <= 0;
    idle_pct      = 0;
    now_val       = '{0, 0, 1, 1, 0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed lines under the reset time
    send_text("* * * * * x");
    send_text("0 0 1 1 0 ");
    send_text(" 0 1 1 0\tcmd");
    send_text("1,0 0-5 1 1 0 ");
    send_text("0,9x 0 * * * ");
    send_text("0-3z9 * * * * ");
    send_text(",5 -0 1 1 0 ");
    send_text("999 * * * * ");
    send_text("*5 * * * * ");
    send_text("a * * * * ");
    send_text("* *");
    line_buf.delete();
    put_text("* * ");
    line_buf.push_back(CH_NUL);
    put_text("* * * ");
    send_line();
    line_buf.delete();
    line_buf.push_back(8'hff);
    send_line();

    // random lines under several time settings and idling modes
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
      case (p)
        0: load_time(0, 0, 0, 0, 0);
        1: load_time(59, 23, 31, 12, 6);
        2: load_time(63, 31, 31, 15, 7);
        default: begin
          if (p % 2)
            load_time($urandom_range(63), $urandom_range(63), $urandom_range(63),
                      $urandom_range(63), $urandom_range(63));
          else
            load_time($urandom_range(59), $urandom_range(23), $urandom_range(31, 1),
                      $urandom_range(12, 1), $urandom_range(6));
        end
      endcase
      set_idling(p % 4);
      // long result hold-off while bytes keep coming
      if (p == 4) hold_requests <= hold_requests + 1;
      phase_bytes = 0;
      phase_lines = 0;
      while (phase_bytes < PHASE_BYTES || phase_lines < PHASE_LINES) begin
        build_line();
        send_line();
        phase_bytes += line_buf.size();
        phase_lines++;
        // sender pause until every verdict is back
        if (p == 5 && phase_lines == 4) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
